FILE: src/matrix_inverse_3x3_defines.svh
// assertion macros for the 3x3 matrix inverse checker
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

// same-cycle implication
`define MI3_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MI3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mi3_pkg.sv
// shared widths, width helpers and control word type for the 3x3 matrix inverse
package mi3_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int LANES      = 9;

    typedef struct packed {
        logic             valid;
        logic             sing;
        logic             det_neg;
        logic [LANES-1:0] neg;
    } ctl_t;

    function automatic int cof_w(input int e);
        return 2 * e + 1;
    endfunction

    function automatic int det_w(input int e);
        return 3 * e + 3;
    endfunction

    function automatic int num_w(input int e, input int f);
        return 2 * e + 1 + 2 * f;
    endfunction

    function automatic int cmp_w(input int e, input int f);
        int a;
        int b;
        a = num_w(e, f) + 1;
        b = det_w(e) + e;
        return ((a > b) ? a : b) + 1;
    endfunction

endpackage

FILE: src/mi3_cofactor.sv
// minor products and signed cofactors, two register stages
module mi3_cofactor #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  logic                                          valid_in,
    input  logic signed [ELEM_WIDTH-1:0]                  a [9],
    output logic signed [mi3_pkg::cof_w(ELEM_WIDTH)-1:0]  cof [9],
    output logic signed [ELEM_WIDTH-1:0]                  row0 [3],
    output logic                                          valid_out
);
    localparam int E  = ELEM_WIDTH;
    localparam int PW = 2 * E;
    localparam int CW = mi3_pkg::cof_w(E);

    logic signed [PW-1:0] prod_reg [18];
    logic signed [CW-1:0] cof_reg [9];
    logic signed [E-1:0]  row1_reg [3];
    logic signed [E-1:0]  row2_reg [3];
    logic                 v1_reg;
    logic                 v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_row
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                row1_reg[c] <= a[c];
                row2_reg[c] <= row1_reg[c];
            end
        end
        assign row0[c] = row2_reg[c];
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_cof
        localparam int R  = k / 3;
        localparam int C  = k % 3;
        localparam int R1 = (R == 0) ? 1 : 0;
        localparam int R2 = (R == 2) ? 1 : 2;
        localparam int C1 = (C == 0) ? 1 : 0;
        localparam int C2 = (C == 2) ? 1 : 2;
        localparam bit ODD = ((R + C) % 2) == 1;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[2*k]   <= a[R1*3+C1] * a[R2*3+C2];
                prod_reg[2*k+1] <= a[R1*3+C2] * a[R2*3+C1];
                if (ODD)
                    cof_reg[k] <= CW'(prod_reg[2*k+1]) - CW'(prod_reg[2*k]);
                else
                    cof_reg[k] <= CW'(prod_reg[2*k]) - CW'(prod_reg[2*k+1]);
            end
        end
        assign cof[k] = cof_reg[k];
    end

    assign valid_out = v2_reg;
endmodule

FILE: src/mi3_det.sv
// determinant by split products, then magnitudes and signs for the divider lanes
module mi3_det #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                en,
    input  logic                                                valid_in,
    input  logic signed [mi3_pkg::cof_w(ELEM_WIDTH)-1:0]        cof [9],
    input  logic signed [ELEM_WIDTH-1:0]                        row0 [3],
    output logic [mi3_pkg::num_w(ELEM_WIDTH, FRAC_BITS)-1:0]    num [9],
    output logic [mi3_pkg::det_w(ELEM_WIDTH)-1:0]               den,
    output mi3_pkg::ctl_t                                       ctl
);
    localparam int E  = ELEM_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int CW = mi3_pkg::cof_w(E);
    localparam int DW = mi3_pkg::det_w(E);
    localparam int NW = mi3_pkg::num_w(E, F);
    localparam int MW = 2 * E + 1;

    logic signed [MW-1:0] lo_reg [3];
    logic signed [MW-1:0] hi_reg [3];
    logic signed [CW-1:0] cof3_reg [9];
    logic signed [CW-1:0] cof4_reg [9];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;
    logic [NW-1:0]        num_reg [9];
    logic [DW-1:0]        den_reg;
    logic [8:0]           neg_reg;
    logic                 det_neg_reg;
    logic                 sing_reg;
    logic                 v3_reg;
    logic                 v4_reg;
    logic                 v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= valid_in;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // low half unsigned, high half signed
    for (genvar c = 0; c < 3; c++)
    begin : g_part
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[c] <= row0[c] * $signed({1'b0, cof[c][E-1:0]});
                hi_reg[c] <= row0[c] * $signed(cof[c][CW-1:E]);
            end
        end
    end

    always_comb
    begin
        det_next = DW'(lo_reg[0]) + DW'(lo_reg[1]) + DW'(lo_reg[2])
                 + (DW'(hi_reg[0]) <<< E) + (DW'(hi_reg[1]) <<< E)
                 + (DW'(hi_reg[2]) <<< E);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg     <= det_next;
            den_reg     <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            det_neg_reg <= det_reg[DW-1];
            sing_reg    <= (det_reg == '0);
        end
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        // transpose of the cofactor matrix
        localparam int SRC = (k % 3) * 3 + (k / 3);
        logic [CW-1:0] mag;

        assign mag = cof4_reg[SRC][CW-1] ? CW'(-cof4_reg[SRC]) : CW'(cof4_reg[SRC]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cof3_reg[k] <= cof[k];
                cof4_reg[k] <= cof3_reg[k];
                num_reg[k]  <= NW'(mag) << (2 * F);
                neg_reg[k]  <= cof4_reg[SRC][CW-1] ^ det_reg[DW-1];
            end
        end
        assign num[k] = num_reg[k];
    end

    assign den         = den_reg;
    assign ctl.valid   = v5_reg;
    assign ctl.sing    = sing_reg;
    assign ctl.det_neg = det_neg_reg;
    assign ctl.neg     = neg_reg;
endmodule

FILE: src/mi3_div_stage.sv
// one restoring division step across all nine lanes
module mi3_div_stage #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS,
    parameter int SHIFT      = 0
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                en,
    input  logic [mi3_pkg::num_w(ELEM_WIDTH, FRAC_BITS)-1:0]    rem_in [9],
    input  logic [ELEM_WIDTH:0]                                 q_in [9],
    input  logic [mi3_pkg::det_w(ELEM_WIDTH)-1:0]               den_in,
    input  mi3_pkg::ctl_t                                       ctl_in,
    output logic [mi3_pkg::num_w(ELEM_WIDTH, FRAC_BITS)-1:0]    rem_out [9],
    output logic [ELEM_WIDTH:0]                                 q_out [9],
    output logic [mi3_pkg::det_w(ELEM_WIDTH)-1:0]               den_out,
    output mi3_pkg::ctl_t                                       ctl_out
);
    localparam int E    = ELEM_WIDTH;
    localparam int NW   = mi3_pkg::num_w(E, FRAC_BITS);
    localparam int DW   = mi3_pkg::det_w(E);
    localparam int CMPW = mi3_pkg::cmp_w(E, FRAC_BITS);

    logic [CMPW-1:0]  dsh;
    logic [NW-1:0]    rem_reg [9];
    logic [E:0]       q_reg [9];
    logic [DW-1:0]    den_reg;
    mi3_pkg::ctl_t    ctl_reg;

    assign dsh = CMPW'(den_in) << SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            den_reg <= den_in;
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        logic ge;

        assign ge = CMPW'(rem_in[k]) >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? rem_in[k] - NW'(dsh) : rem_in[k];
                q_reg[k]   <= {q_in[k][E-1:0], ge};
            end
        end
        assign rem_out[k] = rem_reg[k];
        assign q_out[k]   = q_reg[k];
    end

    assign den_out = den_reg;
    assign ctl_out = ctl_reg;
endmodule

FILE: src/mi3_round.sv
// rounding, saturation and singular forcing, ends in the output register
module mi3_round #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                en,
    input  logic [mi3_pkg::num_w(ELEM_WIDTH, FRAC_BITS)-1:0]    rem [9],
    input  logic [ELEM_WIDTH:0]                                 q [9],
    input  logic [mi3_pkg::det_w(ELEM_WIDTH)-1:0]               den,
    input  mi3_pkg::ctl_t                                       ctl,
    output logic signed [ELEM_WIDTH-1:0]                        inv [9],
    output logic signed [ELEM_WIDTH-1:0]                        determinant,
    output logic                                                singular,
    output logic                                                valid_out
);
    localparam int E    = ELEM_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DW   = mi3_pkg::det_w(E);
    localparam int CMPW = mi3_pkg::cmp_w(E, F);

    logic [E:0]          qr_reg [9];
    logic [8:0]          over_reg;
    logic [DW:0]         dq_reg;
    mi3_pkg::ctl_t       ctl_reg;
    logic                valid_reg;
    logic                sing_reg;
    logic signed [E-1:0] inv_reg [9];
    logic signed [E-1:0] det_reg;
    logic [E:0]          lim_pos;
    logic [E:0]          lim_neg;
    logic [DW:0]         dlim;
    logic [DW:0]         dmag;
    logic [DW:0]         dval;

    assign lim_neg = (E+1)'(1) << (E - 1);
    assign lim_pos = lim_neg - (E+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl_reg   <= ctl;
            valid_reg <= ctl_reg.valid;
        end
    end

    // ties away from zero
    always_ff @(posedge clk)
    begin
        if (en)
            dq_reg <= (DW+1)'(den >> (2 * F)) + (DW+1)'(den[2*F-1]);
    end

    assign dlim = ctl_reg.det_neg ? (DW+1)'(lim_neg) : (DW+1)'(lim_pos);
    assign dmag = (dq_reg > dlim) ? dlim : dq_reg;
    assign dval = ctl_reg.det_neg ? (DW+1)'(-dmag) : dmag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= ctl_reg.sing;
            det_reg  <= ctl_reg.sing ? '0 : $signed(dval[E-1:0]);
        end
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        logic       up;
        logic [E:0] lim;
        logic [E:0] mag;
        logic [E:0] val;

        assign up  = (CMPW'(rem[k]) << 1) >= CMPW'(den);
        assign lim = ctl_reg.neg[k] ? lim_neg : lim_pos;
        assign mag = (over_reg[k] || (qr_reg[k] > lim)) ? lim : qr_reg[k];
        assign val = ctl_reg.neg[k] ? (E+1)'(-mag) : mag;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                over_reg[k] <= q[k][E];
                qr_reg[k]   <= {1'b0, q[k][E-1:0]} + (E+1)'(up);
                inv_reg[k]  <= ctl_reg.sing ? '0 : $signed(val[E-1:0]);
            end
        end
        assign inv[k] = inv_reg[k];
    end

    assign determinant = det_reg;
    assign singular    = sing_reg;
    assign valid_out   = valid_reg;
endmodule

FILE: src/matrix_inverse_3x3.sv
// 3x3 matrix inverse by adjugate, fully pipelined top level
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  input   | in_valid  | in_stall  | in_r0c0 .. in_r2c2
//  output  | out_valid | out_stall | inv_r0c0 .. inv_r2c2, determinant, singular
//
// one word enters per cycle while in_stall is low; the pipeline has
// ELEM_WIDTH + 1 restoring division steps, one per register stage
// the nine lanes share one divisor, the determinant magnitude, per stage
// reset clears only the valid and control registers; the pipeline holds whole
// while out_stall is high with a word waiting, and in_stall follows that condition
module matrix_inverse_3x3 #(
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS,
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c2,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c2,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c2,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c2,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c2,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c2,
    output logic signed [ELEM_WIDTH-1:0] determinant,
    output logic                         singular
);
    localparam int E  = ELEM_WIDTH;
    localparam int CW = mi3_pkg::cof_w(E);
    localparam int DW = mi3_pkg::det_w(E);
    localparam int NW = mi3_pkg::num_w(E, FRAC_BITS);
    localparam int NS = E + 1;

    logic                en;
    logic signed [E-1:0] a [9];
    logic signed [CW-1:0] cof [9];
    logic signed [E-1:0] row0 [3];
    logic                cof_valid;
    logic [NW-1:0]       rem_s [NS+1][9];
    logic [E:0]          q_s [NS+1][9];
    logic [DW-1:0]       den_s [NS+1];
    mi3_pkg::ctl_t       ctl_s [NS+1];
    logic signed [E-1:0] inv [9];

    assign in_stall = out_valid && out_stall;
    assign en       = !in_stall;

    assign a[0] = in_r0c0;
    assign a[1] = in_r0c1;
    assign a[2] = in_r0c2;
    assign a[3] = in_r1c0;
    assign a[4] = in_r1c1;
    assign a[5] = in_r1c2;
    assign a[6] = in_r2c0;
    assign a[7] = in_r2c1;
    assign a[8] = in_r2c2;

    mi3_cofactor #(
        .ELEM_WIDTH (E)
    ) u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .a         (a),
        .cof       (cof),
        .row0      (row0),
        .valid_out (cof_valid)
    );

    mi3_det #(
        .ELEM_WIDTH (E),
        .FRAC_BITS  (FRAC_BITS)
    ) u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (cof_valid),
        .cof      (cof),
        .row0     (row0),
        .num      (rem_s[0]),
        .den      (den_s[0]),
        .ctl      (ctl_s[0])
    );

    for (genvar k = 0; k < 9; k++)
    begin : g_qinit
        assign q_s[0][k] = '0;
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_div
        mi3_div_stage #(
            .ELEM_WIDTH (E),
            .FRAC_BITS  (FRAC_BITS),
            .SHIFT      (E - s)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .rem_in  (rem_s[s]),
            .q_in    (q_s[s]),
            .den_in  (den_s[s]),
            .ctl_in  (ctl_s[s]),
            .rem_out (rem_s[s+1]),
            .q_out   (q_s[s+1]),
            .den_out (den_s[s+1]),
            .ctl_out (ctl_s[s+1])
        );
    end

    mi3_round #(
        .ELEM_WIDTH (E),
        .FRAC_BITS  (FRAC_BITS)
    ) u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .rem         (rem_s[NS]),
        .q           (q_s[NS]),
        .den         (den_s[NS]),
        .ctl         (ctl_s[NS]),
        .inv         (inv),
        .determinant (determinant),
        .singular    (singular),
        .valid_out   (out_valid)
    );

    assign inv_r0c0 = inv[0];
    assign inv_r0c1 = inv[1];
    assign inv_r0c2 = inv[2];
    assign inv_r1c0 = inv[3];
    assign inv_r1c1 = inv[4];
    assign inv_r1c2 = inv[5];
    assign inv_r2c0 = inv[6];
    assign inv_r2c1 = inv[7];
    assign inv_r2c2 = inv[8];
endmodule

FILE: src/mi3_checker.sv
// port-level assertions for the 3x3 matrix inverse, with bind
`include "matrix_inverse_3x3_defines.svh"

module mi3_checker #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [ELEM_WIDTH-1:0] inv_r0c0,
    input logic signed [ELEM_WIDTH-1:0] inv_r1c1,
    input logic signed [ELEM_WIDTH-1:0] inv_r2c2,
    input logic signed [ELEM_WIDTH-1:0] determinant,
    input logic                         singular
);
    `MI3_ASSERT_IMP(a_sing_zero, out_valid && singular, determinant == '0 && inv_r0c0 == '0 && inv_r1c1 == '0 && inv_r2c2 == '0, "singular word carries non-zero data")
    `MI3_ASSERT_IMP(a_in_stall, in_stall, out_valid && out_stall, "input stalled without output back-pressure")
    `MI3_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(determinant) && $stable(singular), "stalled output word changed")
endmodule

bind matrix_inverse_3x3 mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (.*);

FILE: bench/tb_matrix_inverse_3x3.sv
// self-checking testbench for the 3x3 matrix inverse: random idling, exact predictor
`timescale 1ns / 1ps

module tb_matrix_inverse_3x3;

    localparam int EW        = mi3_pkg::ELEM_WIDTH;
    localparam int FB        = mi3_pkg::FRAC_BITS;
    localparam int WIDE      = 200;
    localparam int N_RANDOM  = 900;
    localparam int QUIET_END = 150;
    localparam int WATCHDOG  = 2000;

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [WIDE-1:0] wide_t;

    typedef struct {
        elem_t m[9];
    } matrix_t;

    typedef struct {
        elem_t inv[9];
        elem_t det;
        logic  sing;
    } inverse_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    elem_t in_e[9];
    logic  out_valid;
    logic  out_stall;
    elem_t inv_e[9];
    elem_t determinant;
    logic  singular;

    matrix_t  pending_matrices[$];
    inverse_t expected_inverses[$];
    int       errors;
    int       accepted_in;
    int       total_items;
    int       quiet_cycles;
    int       in_gap;
    int       out_gap;
    bit       calm;
    bit       stim_done;

    matrix_inverse_3x3 i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_r0c0    (in_e[0]),
        .in_r0c1    (in_e[1]),
        .in_r0c2    (in_e[2]),
        .in_r1c0    (in_e[3]),
        .in_r1c1    (in_e[4]),
        .in_r1c2    (in_e[5]),
        .in_r2c0    (in_e[6]),
        .in_r2c1    (in_e[7]),
        .in_r2c2    (in_e[8]),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inv_r0c0   (inv_e[0]),
        .inv_r0c1   (inv_e[1]),
        .inv_r0c2   (inv_e[2]),
        .inv_r1c0   (inv_e[3]),
        .inv_r1c1   (inv_e[4]),
        .inv_r1c2   (inv_e[5]),
        .inv_r2c0   (inv_e[6]),
        .inv_r2c1   (inv_e[7]),
        .inv_r2c2   (inv_e[8]),
        .determinant(determinant),
        .singular   (singular)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // rounded quotient, ties away from zero, saturated to the element width
    function automatic elem_t round_div_sat(input wide_t num, input wide_t den);
        logic  neg;
        wide_t n_abs;
        wide_t d_abs;
        wide_t q;
        wide_t r;
        wide_t lim;
        neg   = num[WIDE-1] ^ den[WIDE-1];
        n_abs = num[WIDE-1] ? -num : num;
        d_abs = den[WIDE-1] ? -den : den;
        q     = n_abs / d_abs;
        r     = n_abs % d_abs;
        if (2 * r >= d_abs)
            q = q + 1;
        lim = neg ? (wide_t'(1) <<< (EW - 1)) : ((wide_t'(1) <<< (EW - 1)) - 1);
        if (q > lim)
            q = lim;
        return neg ? elem_t'(-q) : elem_t'(q);
    endfunction

    function automatic inverse_t adjugate_inverse(input matrix_t a);
        inverse_t res;
        wide_t    am[3][3];
        wide_t    cof[3][3];
        wide_t    det;
        int       r1;
        int       r2;
        int       c1;
        int       c2;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                am[r][c] = wide_t'(a.m[r * 3 + c]);
        for (int r = 0; r < 3; r++)
        begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            for (int c = 0; c < 3; c++)
            begin
                c1 = (c == 0) ? 1 : 0;
                c2 = (c == 2) ? 1 : 2;
                cof[r][c] = am[r1][c1] * am[r2][c2] - am[r1][c2] * am[r2][c1];
                if ((r + c) % 2 == 1)
                    cof[r][c] = -cof[r][c];
            end
        end
        det = am[0][0] * cof[0][0] + am[0][1] * cof[0][1] + am[0][2] * cof[0][2];
        res.sing = (det == 0);
        if (res.sing)
        begin
            foreach (res.inv[k])
                res.inv[k] = '0;
            res.det = '0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    res.inv[i * 3 + j] = round_div_sat(cof[j][i] <<< (2 * FB), det);
            res.det = round_div_sat(det, wide_t'(1) <<< (2 * FB));
        end
        return res;
    endfunction

    function automatic elem_t rand_elem(input int kind);
        case (kind)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            2: return elem_t'($signed($urandom_range(0, 1023)) - 512);
            default: return elem_t'($signed($urandom_range(0, 2 << FB)) - (1 << FB));
        endcase
    endfunction

    task automatic add_matrix(input matrix_t a);
        pending_matrices.push_back(a);
        total_items++;
    endtask

    initial
    begin
        matrix_t a;
        int      kind;
        errors      = 0;
        accepted_in = 0;
        total_items = 0;
        stim_done   = 0;
        // directed: zero, identity, extremes, rank-deficient, tiny and huge determinants
        foreach (a.m[k]) a.m[k] = '0;
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = (k % 4 == 0) ? elem_t'(1 << FB) : '0;
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = (k % 4 == 0) ? elem_t'(-(2 << FB)) : '0;
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = (k % 4 == 0) ? {1'b0, {(EW-1){1'b1}}} : '0;
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = (k % 4 == 0) ? {1'b1, {(EW-1){1'b0}}} : '0;
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = (k % 4 == 0) ? elem_t'(1) : '0;
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = {1'b1, {(EW-1){1'b0}}};
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = (k % 2 == 0) ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = elem_t'(-1);
        a.m[0] = elem_t'(1);
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = elem_t'((k + 1) << FB);
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = (k % 4 == 0) ? elem_t'(1 << (FB - 4)) : '0;
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = (k % 4 == 0) ? elem_t'(1 << (FB + 12)) : '0;
        add_matrix(a);
        foreach (a.m[k]) a.m[k] = '0;
        a.m[2] = elem_t'(1 << FB);
        a.m[4] = elem_t'(-(3 << FB));
        a.m[6] = elem_t'(5 << FB);
        add_matrix(a);
        for (int k = 0; k < 6; k++)
        begin
            foreach (a.m[j]) a.m[j] = elem_t'($urandom);
            add_matrix(a);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            kind = $urandom_range(0, 3);
            foreach (a.m[k]) a.m[k] = rand_elem(kind);
            // some with a repeated row so the exact determinant is zero
            if ($urandom_range(0, 9) == 0)
                for (int c = 0; c < 3; c++)
                    a.m[6 + c] = a.m[3 + c];
            add_matrix(a);
        end
        stim_done = 1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            foreach (in_e[k])
                in_e[k] <= '0;
            in_gap <= 0;
        end
        else
        begin
            calm = (accepted_in > total_items - 100);
            if (!(in_valid && in_stall))
            begin
                if (in_valid && !in_stall)
                    accepted_in <= accepted_in + 1;
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (pending_matrices.size() > 0)
                begin
                    matrix_t a;
                    a = pending_matrices.pop_front();
                    expected_inverses.push_back(adjugate_inverse(a));
                    in_valid <= 1'b1;
                    foreach (in_e[k])
                        in_e[k] <= a.m[k];
                    if (!calm && $urandom_range(0, 5) == 0)
                        in_gap <= $urandom_range(1, 4);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_inverses.size() == 0)
                begin
                    $display("%0t: unexpected word from block", $time);
                    errors++;
                end
                else
                begin
                    inverse_t e;
                    e = expected_inverses.pop_front();
                    foreach (e.inv[k])
                        if (inv_e[k] !== e.inv[k])
                        begin
                            $display("%0t: inv[%0d] expected %0d actual %0d",
                                     $time, k, e.inv[k], inv_e[k]);
                            errors++;
                        end
                    if (determinant !== e.det)
                    begin
                        $display("%0t: determinant expected %0d actual %0d",
                                 $time, e.det, determinant);
                        errors++;
                    end
                    if (singular !== e.sing)
                    begin
                        $display("%0t: singular expected %0b actual %0b",
                                 $time, e.sing, singular);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= out_gap - 1;
            end
            else if (accepted_in < total_items - 100 && $urandom_range(0, 6) == 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= $urandom_range(0, 3);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("Verification failed");
                $finish;
            end
            if (stim_done && pending_matrices.size() == 0 && !in_valid
                && expected_inverses.size() == 0)
            begin
                repeat (QUIET_END) @(posedge clk);
                if (errors == 0)
                    $display("Verification passed");
                else
                    $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
